// ===== rtl/core/rpat_pkg.sv =====
`timescale 1ns / 1ps
package rpat_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned PREFIX_W        = 24;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned ACT_W           = 2;

  localparam logic [ACT_W-1:0] ACT_ADDED   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RENEWED = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DROPPED = 2'd2;
  localparam logic [ACT_W-1:0] ACT_EXPIRED = 2'd3;

  typedef struct packed {
    logic [PREFIX_W-1:0] network_prefix;
    logic [TIME_W-1:0]   now_time;
    logic [TIME_W-1:0]   ttl_seconds;
  } rpat_in_t;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [PREFIX_W-1:0] result_prefix;
    logic [TIME_W-1:0]   expiry_time;
    logic                last_result;
  } rpat_out_t;

  typedef struct packed {
    logic [PREFIX_W-1:0] prefix;
    logic [TIME_W-1:0]   expiry;
  } rpat_entry_t;

  typedef struct packed {
    logic hit;
    logic expired;
    logic later;
  } rpat_flags_t;

endpackage

// ===== rtl/core/rpat_mem.sv =====
`timescale 1ns / 1ps
module rpat_mem #(
  parameter int unsigned TABLE_DEPTH = rpat_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]      wr_addr,
  input  rpat_pkg::rpat_entry_t               wr_data,
  input  logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
  output rpat_pkg::rpat_entry_t               rd_data
);

  rpat_pkg::rpat_entry_t mem [TABLE_DEPTH];
  rpat_pkg::rpat_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/rpat_cmp.sv =====
`timescale 1ns / 1ps
module rpat_cmp (
  input  rpat_pkg::rpat_entry_t               entry,
  input  logic [rpat_pkg::PREFIX_W-1:0]       key,
  input  logic [rpat_pkg::TIME_W-1:0]         now,
  input  logic [rpat_pkg::TIME_W-1:0]         sum,
  output rpat_pkg::rpat_flags_t               flags
);

  always_comb begin
    flags.hit     = (entry.prefix == key);
    flags.expired = (entry.expiry < now);
    flags.later   = (sum > entry.expiry);
  end

endmodule

// ===== rtl/core/rpat_ctrl.sv =====
`timescale 1ns / 1ps
module rpat_ctrl #(
  parameter int unsigned TABLE_DEPTH = rpat_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  rpat_pkg::rpat_in_t                  in_data,
  output logic                                out_valid,
  output rpat_pkg::rpat_out_t                 out_data,
  output logic                                wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]      wr_addr,
  output rpat_pkg::rpat_entry_t               wr_data,
  output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
  input  rpat_pkg::rpat_entry_t               rd_data,
  output logic [rpat_pkg::PREFIX_W-1:0]       key,
  output logic [rpat_pkg::TIME_W-1:0]         now,
  output logic [rpat_pkg::TIME_W-1:0]         sum,
  input  rpat_pkg::rpat_flags_t               flags
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TW = rpat_pkg::TIME_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOOK  = 5'b00010,
    ST_HEAD  = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_FIN   = 5'b10000
  } rpat_state_t;

  rpat_state_t                 state_r, state_nxt;
  logic [rpat_pkg::PREFIX_W-1:0] key_r, key_nxt;
  logic [TW-1:0]               now_r, now_nxt;
  logic [TW-1:0]               sum_r, sum_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               rp_r, rp_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic [CW-1:0]               rd_pos_r, rd_pos_nxt;
  logic                        hit_r, hit_nxt;
  logic [CW-1:0]               hpos_r, hpos_nxt;
  logic [TW-1:0]               hexp_r, hexp_nxt;
  logic                        store_r, store_nxt;
  logic [CW-1:0]               wp_r, wp_nxt;
  rpat_pkg::rpat_out_t         pend_r, pend_nxt;
  logic                        out_valid_r, out_valid_nxt;
  rpat_pkg::rpat_out_t         out_data_r, out_data_nxt;
  logic [TW:0]                 sum_full;
  logic                        scan_done;

  assign sum_full  = {1'b0, in_data.now_time} + {1'b0, in_data.ttl_seconds};
  assign scan_done = (rp_r == cnt_r);
  assign rd_addr   = rp_r[AW-1:0];
  assign key       = key_r;
  assign now       = now_r;
  assign sum       = sum_r;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    rp_nxt        = rp_r;
    rd_vld_nxt    = 1'b0;
    rd_pos_nxt    = rd_pos_r;
    hit_nxt       = hit_r;
    hpos_nxt      = hpos_r;
    hexp_nxt      = hexp_r;
    store_nxt     = store_r;
    wp_nxt        = wp_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = wp_r[AW-1:0];
    wr_data       = rd_data;

    if ((state_r == ST_LOOK || state_r == ST_SWEEP) && !scan_done) begin
      rp_nxt     = rp_r + CW'(1);
      rd_vld_nxt = 1'b1;
      rd_pos_nxt = rp_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt   = in_data.network_prefix;
          now_nxt   = in_data.now_time;
          sum_nxt   = sum_full[TW] ? {TW{1'b1}} : sum_full[TW-1:0];
          rp_nxt    = '0;
          hit_nxt   = 1'b0;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (rd_vld_r && flags.hit && !hit_r) begin
          hit_nxt  = 1'b1;
          hpos_nxt = rd_pos_r;
          hexp_nxt = flags.later ? sum_r : rd_data.expiry;
        end
        if (scan_done) begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        pend_nxt.result_prefix = key_r;
        pend_nxt.last_result   = 1'b0;
        if (hit_r) begin
          pend_nxt.action      = rpat_pkg::ACT_RENEWED;
          pend_nxt.expiry_time = hexp_r;
          store_nxt            = 1'b1;
        end else if (cnt_r >= CW'(TABLE_DEPTH)) begin
          pend_nxt.action      = rpat_pkg::ACT_DROPPED;
          pend_nxt.expiry_time = sum_r;
          store_nxt            = 1'b0;
        end else begin
          pend_nxt.action      = rpat_pkg::ACT_ADDED;
          pend_nxt.expiry_time = sum_r;
          hexp_nxt             = sum_r;
          store_nxt            = 1'b1;
        end
        wp_nxt    = (hit_r || cnt_r < CW'(TABLE_DEPTH)) ? CW'(1) : '0;
        rp_nxt    = '0;
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (rd_vld_r && !(hit_r && rd_pos_r == hpos_r)) begin
          if (flags.expired) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt               = pend_r;
            out_data_nxt.last_result   = 1'b0;
            pend_nxt.action            = rpat_pkg::ACT_EXPIRED;
            pend_nxt.result_prefix     = rd_data.prefix;
            pend_nxt.expiry_time       = rd_data.expiry;
            pend_nxt.last_result       = 1'b0;
          end else begin
            wr_en  = 1'b1;
            wr_addr = wp_r[AW-1:0];
            wr_data = rd_data;
            wp_nxt = wp_r + CW'(1);
          end
        end
        if (scan_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        wr_en                    = store_r;
        wr_addr                  = '0;
        wr_data.prefix           = key_r;
        wr_data.expiry           = hexp_r;
        cnt_nxt                  = wp_r;
        out_valid_nxt            = 1'b1;
        out_data_nxt             = pend_r;
        out_data_nxt.last_result = 1'b1;
        state_nxt                = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    sum_r      <= sum_nxt;
    rp_r       <= rp_nxt;
    rd_pos_r   <= rd_pos_nxt;
    hpos_r     <= hpos_nxt;
    hexp_r     <= hexp_nxt;
    store_r    <= store_nxt;
    wp_r       <= wp_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/core/route_prefix_aging_table_core.sv =====
`timescale 1ns / 1ps
// Busy from taking an item until its last result, longer with more entries held
// when the item is taken, as one table memory port pair serves one lookup read
// per entry, then one sweep read per entry; no new item is taken while busy.
// Results leave at most one per cycle and cannot be stalled; the last one comes
// in the first cycle with busy low. Synchronous active-low reset empties the
// table by clearing its fill count.
module route_prefix_aging_table_core #(
  parameter int unsigned TABLE_DEPTH = rpat_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rpat_pkg::rpat_in_t  in_data,
  output logic                out_valid,
  output rpat_pkg::rpat_out_t out_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  rpat_pkg::rpat_entry_t             wr_data;
  logic [AW-1:0]                     rd_addr;
  rpat_pkg::rpat_entry_t             rd_data;
  logic [rpat_pkg::PREFIX_W-1:0]     key;
  logic [rpat_pkg::TIME_W-1:0]       now;
  logic [rpat_pkg::TIME_W-1:0]       sum;
  rpat_pkg::rpat_flags_t             flags;

  rpat_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .key       (key),
    .now       (now),
    .sum       (sum),
    .flags     (flags)
  );

  rpat_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rpat_cmp u_cmp (
    .entry (rd_data),
    .key   (key),
    .now   (now),
    .sum   (sum),
    .flags (flags)
  );

endmodule

// ===== rtl/core/rpat_checker.sv =====
`timescale 1ns / 1ps
module rpat_prop_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input rpat_pkg::rpat_out_t out_data
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transfer accepted without going busy");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_result |-> !busy)
    else $error("final result while still busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> busy)
    else $error("non-final result while idle");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_result |=> !out_valid)
    else $error("result right after final result");

endmodule

bind route_prefix_aging_table_core rpat_prop_checker u_rpat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== tb/rpat_checker.sv =====
`timescale 1ns / 1ps
module rpat_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  rpat_pkg::rpat_in_t  in_data,
  input  logic                out_valid,
  input  rpat_pkg::rpat_out_t out_data,
  output int                  fail_count,
  output int                  pending,
  output int                  updates_seen,
  output int                  added_seen,
  output int                  renewed_seen,
  output int                  dropped_seen,
  output int                  expired_seen
);

  localparam int DEPTH      = rpat_pkg::TABLE_DEPTH_DEF;
  localparam int PRINT_MAX  = 40;

  logic                          slot_valid  [DEPTH];
  logic [rpat_pkg::PREFIX_W-1:0] slot_prefix [DEPTH];
  logic [rpat_pkg::TIME_W-1:0]   slot_expiry [DEPTH];
  int                            slot_rank   [DEPTH];
  int                            slot_fill;

  rpat_pkg::rpat_out_t expected_results [$];

  task automatic predict_table_update(input rpat_pkg::rpat_in_t item);
    logic [rpat_pkg::TIME_W:0]   wide_sum;
    logic [rpat_pkg::TIME_W-1:0] new_expiry;
    int                          hit_slot;
    int                          free_slot;
    int                          old_rank;
    int                          n;
    int                          r;
    logic                        gone      [DEPTH];
    int                          rank_snap [DEPTH];
    rpat_pkg::rpat_out_t         batch     [DEPTH+1];
    hit_slot  = -1;
    free_slot = -1;
    n         = 0;
    wide_sum   = {1'b0, item.now_time} + {1'b0, item.ttl_seconds};
    new_expiry = wide_sum[rpat_pkg::TIME_W] ? '1 : wide_sum[rpat_pkg::TIME_W-1:0];

    for (int i = 0; i < DEPTH; i++) begin
      gone[i] = 1'b0;
      if (slot_valid[i]) begin
        if (hit_slot < 0 && slot_prefix[i] == item.network_prefix) hit_slot = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end

    if (hit_slot >= 0) begin
      if (new_expiry > slot_expiry[hit_slot]) slot_expiry[hit_slot] = new_expiry;
      old_rank = slot_rank[hit_slot];
      for (int i = 0; i < DEPTH; i++)
        if (slot_valid[i] && slot_rank[i] < old_rank) slot_rank[i]++;
      slot_rank[hit_slot] = 0;
      batch[n] = '{rpat_pkg::ACT_RENEWED, item.network_prefix, slot_expiry[hit_slot], 1'b0};
      n++;
    end else if (free_slot < 0 || slot_fill >= DEPTH) begin
      batch[n] = '{rpat_pkg::ACT_DROPPED, item.network_prefix, new_expiry, 1'b0};
      n++;
    end else begin
      for (int i = 0; i < DEPTH; i++)
        if (slot_valid[i]) slot_rank[i]++;
      slot_valid[free_slot]  = 1'b1;
      slot_prefix[free_slot] = item.network_prefix;
      slot_expiry[free_slot] = new_expiry;
      slot_rank[free_slot]   = 0;
      slot_fill++;
      batch[n] = '{rpat_pkg::ACT_ADDED, item.network_prefix, new_expiry, 1'b0};
      n++;
    end

    // sweep from most recent to least recent
    for (r = 0; r < slot_fill; r++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_valid[i] && slot_rank[i] == r) begin
          if (slot_expiry[i] < item.now_time) begin
            gone[i] = 1'b1;
            batch[n] = '{rpat_pkg::ACT_EXPIRED, slot_prefix[i], slot_expiry[i], 1'b0};
            n++;
          end
          break;
        end
      end
    end

    // drop expired entries and close the rank gaps
    for (int i = 0; i < DEPTH; i++) begin
      rank_snap[i] = slot_rank[i];
      if (gone[i]) begin
        slot_valid[i] = 1'b0;
        slot_fill--;
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_valid[i]) begin
        r = 0;
        for (int j = 0; j < DEPTH; j++)
          if (slot_valid[j] && rank_snap[j] < rank_snap[i]) r++;
        slot_rank[i] = r;
      end
    end

    batch[n-1].last_result = 1'b1;
    for (int k = 0; k < n; k++) expected_results.push_back(batch[k]);
  endtask

  task automatic check_result(input rpat_pkg::rpat_out_t got);
    rpat_pkg::rpat_out_t want;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= PRINT_MAX)
        $display("%0t: expected no result, got act=%0d prefix=%06h expiry=%08h last=%0b",
                 $time, got.action, got.result_prefix, got.expiry_time, got.last_result);
    end else begin
      want = expected_results.pop_front();
      if (got.action !== want.action || got.result_prefix !== want.result_prefix ||
          got.expiry_time !== want.expiry_time || got.last_result !== want.last_result) begin
        fail_count++;
        if (fail_count <= PRINT_MAX)
          $display("%0t: expected %0d/%06h/%08h/%0b, got %0d/%06h/%08h/%0b",
                   $time, want.action, want.result_prefix, want.expiry_time,
                   want.last_result, got.action, got.result_prefix,
                   got.expiry_time, got.last_result);
      end
      case (want.action)
        rpat_pkg::ACT_ADDED:   added_seen++;
        rpat_pkg::ACT_RENEWED: renewed_seen++;
        rpat_pkg::ACT_DROPPED: dropped_seen++;
        default:               expired_seen++;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) slot_valid[i] = 1'b0;
      slot_fill = 0;
      expected_results.delete();
    end else begin
      if ($isunknown(out_valid) || $isunknown(busy)) begin
        fail_count++;
        if (fail_count <= PRINT_MAX)
          $display("%0t: unknown handshake expected known values, got busy=%b out_valid=%b",
                   $time, busy, out_valid);
      end
      if (out_valid === 1'b1) check_result(out_data);
      if (start && busy === 1'b0) begin
        predict_table_update(in_data);
        updates_seen++;
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT = 100000;
  localparam int POOL_SIZE   = 24;
  localparam int RAND_ITEMS  = 105;
  localparam int QUIET_FROM  = 85;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  rpat_pkg::rpat_in_t  in_data;
  logic                out_valid;
  rpat_pkg::rpat_out_t out_data;

  int fail_count;
  int pending;
  int updates_seen;
  int added_seen;
  int renewed_seen;
  int dropped_seen;
  int expired_seen;
  int cycle_count = 0;

  logic [rpat_pkg::PREFIX_W-1:0] prefix_pool [POOL_SIZE];
  logic [rpat_pkg::TIME_W-1:0]   base_time;
  bit                            quiet_tail = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  route_prefix_aging_table_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  rpat_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .updates_seen (updates_seen),
    .added_seen   (added_seen),
    .renewed_seen (renewed_seen),
    .dropped_seen (dropped_seen),
    .expired_seen (expired_seen)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_update(input logic [rpat_pkg::PREFIX_W-1:0] prefix,
                             input logic [rpat_pkg::TIME_W-1:0] now_t,
                             input logic [rpat_pkg::TIME_W-1:0] ttl);
    in_data <= '{network_prefix: prefix, now_time: now_t, ttl_seconds: ttl};
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!quiet_tail && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    logic [rpat_pkg::PREFIX_W-1:0] prefix;
    logic [rpat_pkg::TIME_W-1:0]   now_t;
    logic [rpat_pkg::TIME_W-1:0]   ttl;
    int                            roll;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_update(24'h000000, 32'd0, 32'd0);
    send_update(24'hFFFFFF, 32'd1, 32'd0);
    send_update(24'hFFFFFF, 32'd1, 32'd10);
    send_update(24'hFFFFFF, 32'd2, 32'd3);
    // fill the table
    for (int i = 1; i <= 15; i++)
      send_update(rpat_pkg::PREFIX_W'(i * 24'h010101), 32'd5, 32'd100);
    send_update(24'hABCDEF, 32'd6, 32'd0);
    send_update(24'h080808, 32'd7, 32'd0);
    send_update(24'h123456, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_update(24'h5A5A5A, 32'd100, 32'hFFFFFFF0);
    send_update(24'hA5A5A5, 32'd300, 32'd0);
    send_update(24'h5A5A5A, 32'd301, 32'd0);
    wait_all_results();

    prefix_pool[0] = 24'h000000;
    prefix_pool[1] = 24'hFFFFFF;
    for (int i = 2; i < POOL_SIZE; i++) prefix_pool[i] = rpat_pkg::PREFIX_W'($urandom());
    base_time = 32'd1000;

    for (int k = 0; k < RAND_ITEMS; k++) begin
      quiet_tail = (k >= QUIET_FROM);
      if (k == RAND_ITEMS / 2) wait_all_results();
      prefix = ($urandom_range(0, 99) < 80) ? prefix_pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : rpat_pkg::PREFIX_W'($urandom());
      if ($urandom_range(0, 99) < 5) begin
        now_t = $urandom();
      end else begin
        base_time = base_time + $urandom_range(0, 20);
        now_t = base_time;
      end
      roll = $urandom_range(0, 99);
      if (roll < 6)       ttl = $urandom();
      else if (roll < 10) ttl = '0;
      else                ttl = $urandom_range(1, 160);
      send_update(prefix, now_t, ttl);
    end

    wait_all_results();
    repeat (40) @(posedge clk);
    @(negedge clk);
    $display("Covered %0d prefix updates with %0d results checked",
             updates_seen, added_seen + renewed_seen + dropped_seen + expired_seen);
    $display("Actions: %0d added, %0d renewed, %0d dropped on full table, %0d expired",
             added_seen, renewed_seen, dropped_seen, expired_seen);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rpat_pkg.sv
rtl/core/rpat_mem.sv
rtl/core/rpat_cmp.sv
rtl/core/rpat_ctrl.sv
rtl/core/route_prefix_aging_table_core.sv
rtl/core/rpat_checker.sv
tb/rpat_checker.sv
tb/tb_top.sv
